### hw/rtl/whitespace_run_formatter_defines.svh
// assertion macros used by the checker file
`ifndef WHITESPACE_RUN_FORMATTER_DEFINES_SVH
`define WHITESPACE_RUN_FORMATTER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define WSRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsrf check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define WSRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsrf check failed");

`endif

### hw/rtl/wsrf_pkg.sv
package wsrf_pkg;

  localparam int RUN_DEPTH   = 32;
  localparam int STACK_DEPTH = 16;

  localparam int RUN_AW = $clog2(RUN_DEPTH);
  localparam int RUN_LW = $clog2(RUN_DEPTH + 1);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int STK_CW = $clog2(STACK_DEPTH + 1);

  typedef logic [2:0]        mode_t;
  typedef logic [1:0]        opcode_t;
  typedef logic [7:0]        byte_t;
  typedef logic [RUN_AW-1:0] run_addr_t;
  typedef logic [RUN_LW-1:0] run_len_t;
  typedef logic [STK_AW-1:0] stk_addr_t;
  typedef logic [STK_CW-1:0] stk_cnt_t;

  localparam run_len_t RUN_FULL  = run_len_t'(RUN_DEPTH);
  localparam stk_cnt_t STK_FULL  = stk_cnt_t'(STACK_DEPTH);
  localparam stk_cnt_t STK_ONE   = stk_cnt_t'(1);
  localparam stk_cnt_t STK_TWO   = stk_cnt_t'(2);

  localparam opcode_t OP_CHAR  = 2'd0;
  localparam opcode_t OP_FLUSH = 2'd1;
  localparam opcode_t OP_PUSH  = 2'd2;
  localparam opcode_t OP_POP   = 2'd3;

  localparam mode_t MODE_NONE    = 3'd0;
  localparam mode_t MODE_DROP    = 3'd1;
  localparam mode_t MODE_ONE     = 3'd2;
  localparam mode_t MODE_STRIP   = 3'd3;
  localparam mode_t MODE_JOIN    = 3'd4;
  localparam mode_t MODE_NOWL    = 3'd5;
  localparam mode_t MODE_PASS    = 3'd6;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;

  typedef struct packed {
    run_len_t  len;
    run_addr_t first_nl;
    run_addr_t last_nl;
    logic      nl_any;
    logic      nl_multi;
  } run_stat_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    mode_t new_mode;
  } stk_cmd_t;

  function automatic logic is_space(input byte_t c);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### hw/rtl/wsrf_run_buf.sv
module wsrf_run_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  wsrf_pkg::byte_t         wr_data,
  input  logic                    clear,
  input  logic                    rd_en,
  input  wsrf_pkg::run_addr_t     rd_addr,
  output wsrf_pkg::byte_t         rd_data,
  output wsrf_pkg::run_stat_t     stat
);

  wsrf_pkg::byte_t     mem [wsrf_pkg::RUN_DEPTH];
  wsrf_pkg::byte_t     rd_data_r;
  wsrf_pkg::run_len_t  len_r, len_nxt;
  wsrf_pkg::run_addr_t first_r, first_nxt;
  wsrf_pkg::run_addr_t last_r, last_nxt;
  logic                nl_any_r, nl_any_nxt;
  logic                nl_multi_r, nl_multi_nxt;
  logic                do_wr;

  assign do_wr = wr_en && (len_r < wsrf_pkg::RUN_FULL);

  always_comb begin
    len_nxt      = len_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    nl_any_nxt   = nl_any_r;
    nl_multi_nxt = nl_multi_r;
    if (clear) begin
      len_nxt      = '0;
      nl_any_nxt   = 1'b0;
      nl_multi_nxt = 1'b0;
    end else if (do_wr) begin
      len_nxt = len_r + wsrf_pkg::run_len_t'(1);
      if (wr_data == wsrf_pkg::CH_LF) begin
        if (!nl_any_r) begin
          first_nxt = len_r[wsrf_pkg::RUN_AW-1:0];
        end
        last_nxt     = len_r[wsrf_pkg::RUN_AW-1:0];
        nl_multi_nxt = nl_any_r;
        nl_any_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[len_r[wsrf_pkg::RUN_AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      nl_any_r   <= 1'b0;
      nl_multi_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      nl_any_r   <= nl_any_nxt;
      nl_multi_r <= nl_multi_nxt;
    end
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

  assign rd_data       = rd_data_r;
  assign stat.len      = len_r;
  assign stat.first_nl = first_r;
  assign stat.last_nl  = last_r;
  assign stat.nl_any   = nl_any_r;
  assign stat.nl_multi = nl_multi_r;

endmodule

### hw/rtl/wsrf_mode_stack.sv
module wsrf_mode_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  wsrf_pkg::mode_t    cfg_mode,
  input  wsrf_pkg::stk_cmd_t cmd,
  output wsrf_pkg::mode_t    top_mode,
  output logic               above_bottom
);

  wsrf_pkg::mode_t    mem [wsrf_pkg::STACK_DEPTH];
  wsrf_pkg::mode_t    rd_data_r;
  wsrf_pkg::mode_t    init_r, init_nxt;
  wsrf_pkg::mode_t    top_r, top_nxt;
  wsrf_pkg::stk_cnt_t count_r, count_nxt;
  wsrf_pkg::stk_cnt_t below_idx;
  logic               reload_r, reload_nxt;
  logic               reload_bottom_r, reload_bottom_nxt;
  logic               do_push, do_pop;

  assign above_bottom = count_r > wsrf_pkg::STK_ONE;
  assign do_push      = cmd.push && (count_r != wsrf_pkg::STK_FULL);
  assign do_pop       = cmd.pop && above_bottom;
  assign below_idx    = count_r - wsrf_pkg::STK_TWO;

  always_comb begin
    init_nxt          = init_r;
    top_nxt           = top_r;
    count_nxt         = count_r;
    reload_nxt        = 1'b0;
    reload_bottom_nxt = reload_bottom_r;
    if (cfg_wr_en) begin
      init_nxt = cfg_mode;
      if (count_r == wsrf_pkg::STK_ONE) begin
        top_nxt = cfg_mode;
      end
    end
    // new top is loaded from the registered pop read once reload_r is set
    if (reload_r) begin
      top_nxt = reload_bottom_r ? init_r : rd_data_r;
    end
    if (do_push) begin
      top_nxt   = cmd.new_mode;
      count_nxt = count_r + wsrf_pkg::STK_ONE;
    end else if (do_pop) begin
      count_nxt         = count_r - wsrf_pkg::STK_ONE;
      reload_nxt        = 1'b1;
      reload_bottom_nxt = (count_r == wsrf_pkg::STK_TWO);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count_r[wsrf_pkg::STK_AW-1:0]] <= cmd.new_mode;
    end
    if (do_pop) begin
      rd_data_r <= mem[below_idx[wsrf_pkg::STK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r          <= wsrf_pkg::MODE_PASS;
      top_r           <= wsrf_pkg::MODE_PASS;
      count_r         <= wsrf_pkg::STK_ONE;
      reload_r        <= 1'b0;
      reload_bottom_r <= 1'b0;
    end else begin
      init_r          <= init_nxt;
      top_r           <= top_nxt;
      count_r         <= count_nxt;
      reload_r        <= reload_nxt;
      reload_bottom_r <= reload_bottom_nxt;
    end
  end

  assign top_mode = top_r;

endmodule

### hw/rtl/whitespace_run_formatter.sv
// Whitespace run formatter: bytes come in as in_* beats and leave as out_* beats, one result per
// beat; a pop also answers with a reply beat that carries the removed mode. Whitespace is held in a
// 32-entry run buffer and rewritten by the mode on top of a 16-entry mode stack when a non-space
// byte (any byte in pass mode), flush, push or pop above the bottom ends the run. An item with no
// result keeps in_stall low; one with results holds it until its last result is registered.
// Run bytes leave the buffer's single read port behind its registered read, one per cycle unless
// out_stall holds them. The output register lets a result wait on out_stall while the next is
// fetched. Configuration (cfg_wr_data = bottom mode) may be written only while the block is idle.
module whitespace_run_formatter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_new_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_popped_mode,
  output logic       out_last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_LIT  = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t state_r, state_nxt, plan_state;

  wsrf_pkg::run_stat_t stat;
  wsrf_pkg::byte_t     rd_data;
  wsrf_pkg::mode_t     top_mode;
  wsrf_pkg::stk_cmd_t  stk_cmd;
  logic                above_bottom;

  logic in_acc;
  logic run_emit, run_store;

  // plan of the accepted item
  wsrf_pkg::run_len_t a_end, b_start, b_end;
  logic               has_b, lit_v, tail_v, tail_kind;
  wsrf_pkg::byte_t    lit_byte, tail_byte;
  wsrf_pkg::mode_t    tail_pop;

  wsrf_pkg::run_len_t rd_ptr_r, rd_ptr_nxt, end_r, end_nxt;
  wsrf_pkg::run_len_t b_start_r, b_start_nxt, b_end_r, b_end_nxt;
  wsrf_pkg::run_len_t ptr_inc;
  logic               has_b_r, has_b_nxt;
  logic               lit_v_r, lit_v_nxt, tail_v_r, tail_v_nxt;
  wsrf_pkg::byte_t    lit_byte_r, lit_byte_nxt, tail_byte_r, tail_byte_nxt;
  logic               tail_kind_r, tail_kind_nxt;
  wsrf_pkg::mode_t    tail_pop_r, tail_pop_nxt;
  logic               pend_r, pend_nxt, pend_last_r, pend_last_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  wsrf_pkg::byte_t    out_byte_r, out_byte_nxt;
  wsrf_pkg::mode_t    out_pop_r, out_pop_nxt;
  logic               out_last_r, out_last_nxt;

  logic out_free, reads_left, move, issue;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  wsrf_run_buf u_run_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && run_store),
    .wr_data (in_char_code),
    .clear   (in_acc && run_emit),
    .rd_en   (issue),
    .rd_addr (rd_ptr_r[wsrf_pkg::RUN_AW-1:0]),
    .rd_data (rd_data),
    .stat    (stat)
  );

  assign stk_cmd.push     = in_acc && (in_opcode == wsrf_pkg::OP_PUSH);
  assign stk_cmd.pop      = in_acc && (in_opcode == wsrf_pkg::OP_POP);
  assign stk_cmd.new_mode = in_new_mode;

  wsrf_mode_stack u_mode_stack (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_mode     (cfg_wr_data),
    .cmd          (stk_cmd),
    .top_mode     (top_mode),
    .above_bottom (above_bottom)
  );

  // what the accepted item emits: an optional span of the run, an optional second span,
  // an optional literal, then an optional trailing byte or pop reply
  always_comb begin
    a_end     = '0;
    b_start   = '0;
    b_end     = '0;
    has_b     = 1'b0;
    lit_v     = 1'b0;
    lit_byte  = wsrf_pkg::CH_SPACE;
    tail_v    = 1'b0;
    tail_kind = wsrf_pkg::KIND_BYTE;
    tail_byte = in_char_code;
    tail_pop  = wsrf_pkg::MODE_NONE;
    run_emit  = 1'b0;
    run_store = 1'b0;
    unique case (in_opcode)
      wsrf_pkg::OP_CHAR: begin
        if ((top_mode == wsrf_pkg::MODE_PASS) || !wsrf_pkg::is_space(in_char_code)) begin
          run_emit = 1'b1;
          tail_v   = 1'b1;
        end else begin
          run_store = 1'b1;
        end
      end
      wsrf_pkg::OP_FLUSH, wsrf_pkg::OP_PUSH: begin
        run_emit = 1'b1;
      end
      wsrf_pkg::OP_POP: begin
        run_emit  = above_bottom;
        tail_v    = 1'b1;
        tail_kind = wsrf_pkg::KIND_POP;
        tail_byte = '0;
        tail_pop  = above_bottom ? top_mode : wsrf_pkg::MODE_NONE;
      end
      default: ;
    endcase
    if (run_emit && (stat.len != '0)) begin
      unique case (top_mode)
        wsrf_pkg::MODE_DROP: ;
        wsrf_pkg::MODE_ONE: begin
          lit_v    = 1'b1;
          lit_byte = wsrf_pkg::CH_SPACE;
        end
        wsrf_pkg::MODE_STRIP: begin
          if (stat.nl_any) begin
            lit_v    = 1'b1;
            lit_byte = wsrf_pkg::CH_LF;
          end else begin
            a_end = stat.len;
          end
        end
        wsrf_pkg::MODE_JOIN: begin
          a_end = stat.nl_any ? wsrf_pkg::run_len_t'(stat.first_nl) : stat.len;
        end
        wsrf_pkg::MODE_NOWL: begin
          if (stat.nl_multi) begin
            a_end   = wsrf_pkg::run_len_t'(stat.first_nl) + wsrf_pkg::run_len_t'(1);
            b_start = wsrf_pkg::run_len_t'(stat.last_nl) + wsrf_pkg::run_len_t'(1);
            b_end   = stat.len;
            has_b   = (b_start != stat.len);
          end else begin
            a_end = stat.len;
          end
        end
        default: begin
          a_end = stat.len;
        end
      endcase
    end
    if (a_end != '0) begin
      plan_state = ST_RUN;
    end else if (lit_v) begin
      plan_state = ST_LIT;
    end else if (tail_v) begin
      plan_state = ST_TAIL;
    end else begin
      plan_state = ST_IDLE;
    end
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign reads_left = (rd_ptr_r != end_r);
  assign move       = (state_r == ST_RUN) && pend_r && out_free;
  assign issue      = (state_r == ST_RUN) && reads_left && (!pend_r || move);
  assign ptr_inc    = rd_ptr_r + wsrf_pkg::run_len_t'(1);

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    end_nxt       = end_r;
    b_start_nxt   = b_start_r;
    b_end_nxt     = b_end_r;
    has_b_nxt     = has_b_r;
    lit_v_nxt     = lit_v_r;
    lit_byte_nxt  = lit_byte_r;
    tail_v_nxt    = tail_v_r;
    tail_kind_nxt = tail_kind_r;
    tail_byte_nxt = tail_byte_r;
    tail_pop_nxt  = tail_pop_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_pop_nxt   = out_pop_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt     = plan_state;
          rd_ptr_nxt    = '0;
          end_nxt       = a_end;
          b_start_nxt   = b_start;
          b_end_nxt     = b_end;
          has_b_nxt     = has_b;
          lit_v_nxt     = lit_v;
          lit_byte_nxt  = lit_byte;
          tail_v_nxt    = tail_v;
          tail_kind_nxt = tail_kind;
          tail_byte_nxt = tail_byte;
          tail_pop_nxt  = tail_pop;
        end
      end
      ST_RUN: begin
        if (move) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = wsrf_pkg::KIND_BYTE;
          out_byte_nxt  = rd_data;
          out_pop_nxt   = wsrf_pkg::MODE_NONE;
          out_last_nxt  = pend_last_r;
          pend_nxt      = 1'b0;
        end
        if (issue) begin
          pend_nxt      = 1'b1;
          pend_last_nxt = (ptr_inc == end_r) && !has_b_r && !lit_v_r && !tail_v_r;
          if ((ptr_inc == end_r) && has_b_r) begin
            rd_ptr_nxt = b_start_r;
            end_nxt    = b_end_r;
            has_b_nxt  = 1'b0;
          end else begin
            rd_ptr_nxt = ptr_inc;
          end
        end else if (!reads_left && (move || !pend_r)) begin
          if (lit_v_r) begin
            state_nxt = ST_LIT;
          end else if (tail_v_r) begin
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = wsrf_pkg::KIND_BYTE;
          out_byte_nxt  = lit_byte_r;
          out_pop_nxt   = wsrf_pkg::MODE_NONE;
          out_last_nxt  = !tail_v_r;
          state_nxt     = tail_v_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tail_kind_r;
          out_byte_nxt  = tail_byte_r;
          out_pop_nxt   = tail_pop_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lit_v_r     <= 1'b0;
      tail_v_r    <= 1'b0;
      has_b_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      lit_v_r     <= lit_v_nxt;
      tail_v_r    <= tail_v_nxt;
      has_b_r     <= has_b_nxt;
    end
    rd_ptr_r    <= rd_ptr_nxt;
    end_r       <= end_nxt;
    b_start_r   <= b_start_nxt;
    b_end_r     <= b_end_nxt;
    lit_byte_r  <= lit_byte_nxt;
    tail_kind_r <= tail_kind_nxt;
    tail_byte_r <= tail_byte_nxt;
    tail_pop_r  <= tail_pop_nxt;
    pend_last_r <= pend_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_pop_r   <= out_pop_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_popped_mode = out_pop_r;
  assign out_last        = out_last_r;

endmodule

### hw/rtl/wsrf_checker.sv
`include "whitespace_run_formatter_defines.svh"

module wsrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_byte,
  input logic [2:0] out_popped_mode,
  input logic       out_last
);

  // held result beat keeps its payload
  `WSRF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_popped_mode) && $stable(out_last))

  // a pop always owes a reply, so input is held right after it
  `WSRF_ASSERT_NEXT(a_pop_holds_input, in_valid && !in_stall && (in_opcode == wsrf_pkg::OP_POP), in_stall)

  // pop reply closes its item and carries no byte
  `WSRF_ASSERT_NOW(a_pop_reply_shape, out_valid && (out_kind == wsrf_pkg::KIND_POP), out_last && (out_byte == 8'h00))

  // byte beats carry no mode
  `WSRF_ASSERT_NOW(a_byte_no_mode, out_valid && (out_kind == wsrf_pkg::KIND_BYTE), out_popped_mode == wsrf_pkg::MODE_NONE)

endmodule

bind whitespace_run_formatter wsrf_checker u_wsrf_checker (.*);

### tb/tb_whitespace_run_formatter.sv
`timescale 1ns / 1ps

module tb_whitespace_run_formatter;

  localparam wsrf_pkg::mode_t MODE_SEVEN  = 3'd7;
  localparam wsrf_pkg::byte_t CH_VT       = 8'h0B;
  localparam wsrf_pkg::byte_t CH_FF       = 8'h0C;
  localparam int              QUIET_LIMIT = 2000;
  localparam int              PHASE_ITEMS = 24;

  class ws_scoreboard;
    typedef struct packed {
      logic            kind;
      wsrf_pkg::byte_t data;
      wsrf_pkg::mode_t popped;
      logic            last;
    } beat_t;

    beat_t           expected_q[$];
    wsrf_pkg::byte_t run_buf[wsrf_pkg::RUN_DEPTH];
    int              run_len;
    wsrf_pkg::mode_t mode_stk[wsrf_pkg::STACK_DEPTH];
    int              depth;
    int              errors;

    function new();
      run_len     = 0;
      depth       = 1;
      mode_stk[0] = wsrf_pkg::MODE_PASS;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_bottom(wsrf_pkg::mode_t m);
      mode_stk[0] = m;
    endfunction

    function bit is_blank(wsrf_pkg::byte_t c);
      return (c == wsrf_pkg::CH_SPACE) || (c >= wsrf_pkg::CH_TAB && c <= wsrf_pkg::CH_CR);
    endfunction

    function wsrf_pkg::mode_t top_mode();
      return mode_stk[depth-1];
    endfunction

    function void push_beat(logic kind, wsrf_pkg::byte_t b, wsrf_pkg::mode_t m);
      beat_t e;
      e.kind   = kind;
      e.data   = b;
      e.popped = m;
      e.last   = 1'b0;
      expected_q.push_back(e);
    endfunction

    function void push_span(int from, int upto);
      for (int i = from; i < upto; i++) begin
        push_beat(wsrf_pkg::KIND_BYTE, run_buf[i], wsrf_pkg::MODE_NONE);
      end
    endfunction

    // rewrite the buffered whitespace run by the mode on top of the stack
    function void flush_run();
      int first_lf;
      int last_lf;
      if (run_len == 0) return;
      first_lf = run_len;
      last_lf  = run_len;
      for (int i = 0; i < run_len; i++) begin
        if (run_buf[i] == wsrf_pkg::CH_LF) begin
          if (first_lf == run_len) first_lf = i;
          last_lf = i;
        end
      end
      case (top_mode())
        wsrf_pkg::MODE_DROP: ;
        wsrf_pkg::MODE_ONE: push_beat(wsrf_pkg::KIND_BYTE, wsrf_pkg::CH_SPACE, wsrf_pkg::MODE_NONE);
        wsrf_pkg::MODE_STRIP: begin
          if (first_lf == run_len) push_span(0, run_len);
          else push_beat(wsrf_pkg::KIND_BYTE, wsrf_pkg::CH_LF, wsrf_pkg::MODE_NONE);
        end
        wsrf_pkg::MODE_JOIN: push_span(0, first_lf);
        wsrf_pkg::MODE_NOWL: begin
          if (first_lf == last_lf) begin
            push_span(0, run_len);
          end else begin
            push_span(0, first_lf + 1);
            push_span(last_lf + 1, run_len);
          end
        end
        default: push_span(0, run_len);
      endcase
      run_len = 0;
    endfunction

    function void note_beat(wsrf_pkg::opcode_t op, wsrf_pkg::byte_t ch, wsrf_pkg::mode_t nm);
      int              base;
      wsrf_pkg::mode_t popped;
      beat_t           e;
      base = expected_q.size();
      case (op)
        wsrf_pkg::OP_CHAR: begin
          if (top_mode() == wsrf_pkg::MODE_PASS || !is_blank(ch)) begin
            flush_run();
            push_beat(wsrf_pkg::KIND_BYTE, ch, wsrf_pkg::MODE_NONE);
          end else if (run_len < wsrf_pkg::RUN_DEPTH) begin
            run_buf[run_len] = ch;
            run_len++;
          end
        end
        wsrf_pkg::OP_FLUSH: flush_run();
        wsrf_pkg::OP_PUSH: begin
          flush_run();
          if (depth < wsrf_pkg::STACK_DEPTH) begin
            mode_stk[depth] = nm;
            depth++;
          end
        end
        default: begin
          popped = wsrf_pkg::MODE_NONE;
          if (depth > 1) begin
            flush_run();
            popped = top_mode();
            depth--;
          end
          push_beat(wsrf_pkg::KIND_POP, 8'h00, popped);
        end
      endcase
      if (expected_q.size() > base) begin
        e = expected_q.pop_back();
        e.last = 1'b1;
        expected_q.push_back(e);
      end
    endfunction

    function void check_beat(logic kind, wsrf_pkg::byte_t b, wsrf_pkg::mode_t m, logic last);
      beat_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected beat: kind %0d byte %02h popped_mode %0d last %0d", kind, b, m, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (b !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, b);
        errors++;
      end
      if (m !== e.popped) begin
        $error("popped_mode: expected %0d, got %0d", e.popped, m);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_opcode;
  logic [7:0] in_char_code;
  logic [2:0] in_new_mode;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_popped_mode;
  logic       out_last;

  ws_scoreboard    sb;
  bit              gaps_on = 1'b1;
  int              sent    = 0;
  int              quiet   = 0;
  wsrf_pkg::mode_t bottom_order [0:6] = '{wsrf_pkg::MODE_NONE, wsrf_pkg::MODE_STRIP,
                                          wsrf_pkg::MODE_PASS, wsrf_pkg::MODE_DROP,
                                          wsrf_pkg::MODE_JOIN, wsrf_pkg::MODE_ONE,
                                          wsrf_pkg::MODE_NOWL};

  whitespace_run_formatter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_char_code    (in_char_code),
    .in_new_mode     (in_new_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_popped_mode (out_popped_mode),
    .out_last        (out_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_beat(out_kind, out_byte, out_popped_mode, out_last);
    end
    out_stall <= rst_n && gaps_on && ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_whitespace_run_formatter: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(wsrf_pkg::opcode_t op, wsrf_pkg::byte_t ch, wsrf_pkg::mode_t nm);
    if (gaps_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    in_new_mode  <= nm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(op, ch, nm);
    sent++;
  endtask

  task automatic send_char(wsrf_pkg::byte_t ch);
    send(wsrf_pkg::OP_CHAR, ch, wsrf_pkg::mode_t'($urandom_range(7)));
  endtask

  task automatic send_op(wsrf_pkg::opcode_t op, wsrf_pkg::mode_t nm);
    send(op, wsrf_pkg::byte_t'($urandom_range(255)), nm);
  endtask

  // whitespace run of the given length, then one to three non-blank bytes
  task automatic send_word(int run);
    wsrf_pkg::byte_t c;
    for (int i = 0; i < run; i++) begin
      case ($urandom_range(7))
        0:       c = wsrf_pkg::CH_SPACE;
        1:       c = wsrf_pkg::CH_TAB;
        2:       c = CH_VT;
        3:       c = CH_FF;
        4:       c = wsrf_pkg::CH_CR;
        5:       c = wsrf_pkg::CH_SPACE;
        default: c = wsrf_pkg::CH_LF;
      endcase
      send_char(c);
    end
    repeat ($urandom_range(1, 3)) begin
      do c = wsrf_pkg::byte_t'($urandom_range(255)); while (sb.is_blank(c));
      send_char(c);
    end
  endtask

  task automatic fill_stack();
    repeat (wsrf_pkg::STACK_DEPTH + 1) begin
      send_op(wsrf_pkg::OP_PUSH, wsrf_pkg::mode_t'($urandom_range(7)));
    end
  endtask

  task automatic write_bottom(wsrf_pkg::mode_t m);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_bottom(m);
  endtask

  task automatic random_items(int count);
    int stop;
    int pick;
    stop = sent + count;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_word(($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6));
      end else if (pick < 68) begin
        send_op(wsrf_pkg::OP_FLUSH, wsrf_pkg::mode_t'($urandom_range(7)));
      end else if (pick < 80) begin
        send_op(wsrf_pkg::OP_PUSH, wsrf_pkg::mode_t'($urandom_range(7)));
      end else if (pick < 94) begin
        send_op(wsrf_pkg::OP_POP, wsrf_pkg::mode_t'($urandom_range(7)));
      end else if (pick < 96) begin
        fill_stack();
      end else begin
        send(wsrf_pkg::opcode_t'($urandom_range(3)), wsrf_pkg::byte_t'($urandom_range(255)),
             wsrf_pkg::mode_t'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= wsrf_pkg::MODE_PASS;
    in_valid     <= 1'b0;
    in_opcode    <= wsrf_pkg::OP_CHAR;
    in_char_code <= 8'h00;
    in_new_mode  <= wsrf_pkg::MODE_NONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on the bottom keeps the run, then pass mode releases it
    write_bottom(wsrf_pkg::MODE_DROP);
    send_char(wsrf_pkg::CH_SPACE);
    send_op(wsrf_pkg::OP_POP, MODE_SEVEN);
    write_bottom(wsrf_pkg::MODE_PASS);
    send_char("b");
    send_char(8'h00);
    send_char(8'hFF);

    send_op(wsrf_pkg::OP_PUSH, wsrf_pkg::MODE_ONE);
    send_char(wsrf_pkg::CH_TAB);
    send_char(CH_VT);
    send_char(CH_FF);
    send_char(wsrf_pkg::CH_CR);
    send_char("x");

    send_op(wsrf_pkg::OP_PUSH, wsrf_pkg::MODE_STRIP);
    send_char(wsrf_pkg::CH_SPACE);
    send_char(wsrf_pkg::CH_LF);
    send_op(wsrf_pkg::OP_FLUSH, wsrf_pkg::MODE_NONE);

    send_op(wsrf_pkg::OP_PUSH, wsrf_pkg::MODE_NOWL);
    send_char(wsrf_pkg::CH_LF);
    send_char(wsrf_pkg::CH_SPACE);
    send_char(wsrf_pkg::CH_LF);
    send_char(wsrf_pkg::CH_TAB);
    send_op(wsrf_pkg::OP_PUSH, MODE_SEVEN);

    send_char(wsrf_pkg::CH_SPACE);
    send_op(wsrf_pkg::OP_POP, wsrf_pkg::MODE_NONE);
    send_op(wsrf_pkg::OP_FLUSH, wsrf_pkg::MODE_PASS);

    for (int p = 0; p < 7; p++) begin
      write_bottom(bottom_order[p]);
      gaps_on = (p != 2);
      if (p % 3 == 0) send_word($urandom_range(33, 40));
      if (p == 1) fill_stack();
      random_items(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_whitespace_run_formatter: PASS");
    end else begin
      $display("tb_whitespace_run_formatter: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/wsrf_pkg.sv
hw/rtl/wsrf_run_buf.sv
hw/rtl/wsrf_mode_stack.sv
hw/rtl/whitespace_run_formatter.sv
hw/rtl/wsrf_checker.sv
tb/tb_whitespace_run_formatter.sv
